/* src/rq_pkg.sv */
// ----------------------------------------------------------------------------
// rq_pkg: shared types and constants of the int8 per-channel requantizer
// Field widths, register index codes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rq_pkg;

	// field widths
	localparam int AccW  = 32;
	localparam int MultW = 31;
	localparam int ShW   = 6;
	localparam int DataW = 8;
	localparam int IdxW  = 2;

	// scaled value after the doubling high multiply, and its rounded form
	localparam int VW  = 33;
	localparam int QW  = VW + 1;
	localparam int SumW = QW + 1;

	// rounding nudge of the doubling high multiply (one half of 2^31)
	localparam logic signed [2*AccW-1:0] Nudge = 64'sh0000_0000_4000_0000;

	// configuration register indexes
	typedef enum logic [IdxW-1:0] {
		REG_IN_ZP   = 2'd0,
		REG_OUT_ZP  = 2'd1,
		REG_ACT_MIN = 2'd2,
		REG_ACT_MAX = 2'd3
	} reg_idx_t;

	// configuration bundle seen by the datapath
	typedef struct packed {
		logic signed [DataW-1:0] in_zp;
		logic signed [DataW-1:0] out_zp;
		logic signed [DataW-1:0] act_min;
		logic signed [DataW-1:0] act_max;
	} cfg_t;

endpackage

`default_nettype wire

/* src/rq_correct.sv */
// ----------------------------------------------------------------------------
// rq_correct: zero-point correction, bias add and left shift
// Stage 1 forms the input zero point times filter_sum; stage 2 subtracts it
// from the accumulator, adds the bias (32-bit wrap) and applies a positive shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rq_correct import rq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    valid_i,
	input  wire logic signed [AccW-1:0]  acc_i,
	input  wire logic signed [AccW-1:0]  fsum_i,
	input  wire logic signed [AccW-1:0]  bias_i,
	input  wire logic        [MultW-1:0] mult_i,
	input  wire logic signed [ShW-1:0]   sh_i,
	input  wire logic signed [DataW-1:0] in_zp,
	output logic                         valid_o,
	output logic signed [AccW-1:0]       x_o,
	output logic        [MultW-1:0]      mult_o,
	output logic signed [ShW-1:0]        sh_o
);

	logic signed [AccW+DataW-1:0] zp_prod;
	logic                         valid_s1;
	logic        [AccW-1:0]       prod_s1;
	logic        [AccW-1:0]       acc_s1;
	logic        [AccW-1:0]       bias_s1;
	logic        [MultW-1:0]      mult_s1;
	logic signed [ShW-1:0]        sh_s1;
	logic        [AccW-1:0]       corr_sum;
	logic                         sh_pos;
	logic        [AccW-1:0]       shifted;
	logic                         valid_s2;
	logic signed [AccW-1:0]       x_s2;
	logic        [MultW-1:0]      mult_s2;
	logic signed [ShW-1:0]        sh_s2;

	// zero-point times filter sum; only the low word matters (wraps)
	assign zp_prod = (AccW+DataW)'(in_zp) * (AccW+DataW)'(fsum_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= zp_prod[AccW-1:0];
			acc_s1  <= acc_i;
			bias_s1 <= bias_i;
			mult_s1 <= mult_i;
			sh_s1   <= sh_i;
		end
	end

	// correction, bias and left shift, all modulo 2^32
	assign corr_sum = acc_s1 - prod_s1 + bias_s1;
	assign sh_pos   = !sh_s1[ShW-1] && (sh_s1 != '0);
	assign shifted  = sh_pos ? (corr_sum << sh_s1[ShW-2:0]) : corr_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= $signed(shifted);
			mult_s2 <= mult_s1;
			sh_s2   <= sh_s1;
		end
	end

	assign valid_o = valid_s2;
	assign x_o     = x_s2;
	assign mult_o  = mult_s2;
	assign sh_o    = sh_s2;

endmodule

`default_nettype wire

/* src/rq_scale.sv */
// ----------------------------------------------------------------------------
// rq_scale: rounding doubling high multiply by the Q31 multiplier
// Stage 3 registers the 32x32 product; stage 4 adds the nudge and keeps the
// high part, which rounds to nearest with ties toward positive infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module rq_scale import rq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    valid_i,
	input  wire logic signed [AccW-1:0]  x_i,
	input  wire logic        [MultW-1:0] mult_i,
	input  wire logic signed [ShW-1:0]   sh_i,
	output logic                         valid_o,
	output logic signed [VW-1:0]         v_o,
	output logic signed [ShW-1:0]        sh_o
);

	logic signed [2*AccW-1:0] ab;
	logic                     valid_s3;
	logic signed [2*AccW-1:0] ab_s3;
	logic signed [ShW-1:0]    sh_s3;
	logic signed [2*AccW-1:0] nudged;
	logic                     valid_s4;
	logic signed [VW-1:0]     v_s4;
	logic signed [ShW-1:0]    sh_s4;

	// multiplier is never negative: widen it with a zero sign bit
	assign ab = (2*AccW)'(x_i) * (2*AccW)'($signed({1'b0, mult_i}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_s3 <= ab;
			sh_s3 <= sh_i;
		end
	end

	// keeping the high part gives floor((ab + 2^30) / 2^31) for both signs
	// of the product; never saturates with multiplier < 2^31
	assign nudged = ab_s3 + Nudge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4  <= nudged[2*AccW-1:AccW-1];
			sh_s4 <= sh_s3;
		end
	end

	assign valid_o = valid_s4;
	assign v_o     = v_s4;
	assign sh_o    = sh_s4;

endmodule

`default_nettype wire

/* src/rq_round.sv */
// ----------------------------------------------------------------------------
// rq_round: rounding right shift, output offset and activation clamp
// Stage 5 divides by 2^-shift with ties away from zero; stage 6 adds the
// output zero point, clamps and holds the result as the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rq_round import rq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  valid_i,
	input  wire logic signed [VW-1:0]  v_i,
	input  wire logic signed [ShW-1:0] sh_i,
	input  wire cfg_t                  cfg,
	output logic                       valid_o,
	output logic signed [DataW-1:0]    result_o
);

	logic        [ShW-1:0]   rsh;
	logic signed [VW-1:0]    q;
	logic        [QW-1:0]    ones;
	logic        [QW-1:0]    half;
	logic        [QW-1:0]    rem;
	logic                    rnd_up;
	logic                    valid_s5;
	logic        [QW-1:0]    qr_s5;
	logic signed [SumW-1:0]  off_sum;
	logic signed [SumW-1:0]  lo_ext;
	logic signed [SumW-1:0]  hi_ext;
	logic signed [SumW-1:0]  lo_clamped;
	logic signed [SumW-1:0]  clamped;
	logic                    valid_s6;
	logic signed [DataW-1:0] res_s6;

	// right-shift amount 0..32, zero for non-negative shifts
	assign rsh = sh_i[ShW-1] ? ShW'(-sh_i) : '0;

	// floor quotient plus remainder test against one half
	assign q      = v_i >>> rsh;
	assign ones   = (QW'(1) << rsh) - QW'(1);
	assign half   = (ones >> 1) + QW'(1);
	assign rem    = {1'b0, v_i} & ones;
	assign rnd_up = (rsh != '0) && (v_i[VW-1] ? (rem > half) : (rem >= half));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s5 <= {q[VW-1], q} + {{(QW-1){1'b0}}, rnd_up};
		end
	end

	// offset at full width, then lower clamp, then upper clamp
	assign off_sum    = $signed({qr_s5[QW-1], qr_s5})
	                  + $signed({{(SumW-DataW){cfg.out_zp[DataW-1]}}, cfg.out_zp});
	assign lo_ext     = $signed({{(SumW-DataW){cfg.act_min[DataW-1]}}, cfg.act_min});
	assign hi_ext     = $signed({{(SumW-DataW){cfg.act_max[DataW-1]}}, cfg.act_max});
	assign lo_clamped = (off_sum < lo_ext) ? lo_ext : off_sum;
	assign clamped    = (lo_clamped > hi_ext) ? hi_ext : lo_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= clamped[DataW-1:0];
		end
	end

	assign valid_o  = valid_s6;
	assign result_o = res_s6;

endmodule

`default_nettype wire

/* src/int8_per_channel_requantizer.sv */
// ----------------------------------------------------------------------------
// int8_per_channel_requantizer: int8 output stage of a convolution or GEMM
//
// One input transaction carries an accumulator with its channel's filter sum,
// bias, Q31 multiplier and shift; one output transaction carries the int8
// result. Both channels use valid/ready. The configuration channel writes
// input/output zero points and the activation clamp limits; it is always
// ready and must only be used while the pipeline is empty.
//
// Each input transaction passes through six register stages (zero-point
// product, bias and left shift, 32x32 multiply, nudge, rounding shift, offset
// and clamp); the last stage is the output register. Throughput is one
// transaction per cycle unless the receiver stalls with a result waiting.
// Reset empties the pipeline and loads zero points 0, clamp -128..127.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and input ready drops; bubbles inside are kept, nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module int8_per_channel_requantizer import rq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [AccW-1:0]  accumulator,
	input  wire logic signed [AccW-1:0]  filter_sum,
	input  wire logic signed [AccW-1:0]  bias,
	input  wire logic        [MultW-1:0] multiplier,
	input  wire logic signed [ShW-1:0]   shift,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [DataW-1:0]      result,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic        [IdxW-1:0]  cfg_index,
	input  wire logic        [DataW-1:0] cfg_data
);

	cfg_t                  cfg_q;
	logic                  adv;
	logic                  v2;
	logic signed [AccW-1:0]  x2;
	logic        [MultW-1:0] m2;
	logic signed [ShW-1:0]   sh2;
	logic                  v4;
	logic signed [VW-1:0]  val4;
	logic signed [ShW-1:0] sh4;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_zp   <= '0;
			cfg_q.out_zp  <= '0;
			cfg_q.act_min <= 8'sh80;
			cfg_q.act_max <= 8'sh7F;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IN_ZP:   cfg_q.in_zp   <= $signed(cfg_data);
				REG_OUT_ZP:  cfg_q.out_zp  <= $signed(cfg_data);
				REG_ACT_MIN: cfg_q.act_min <= $signed(cfg_data);
				REG_ACT_MAX: cfg_q.act_max <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// pipeline advances unless a finished result is held by the receiver
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	rq_correct u_correct (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.valid_i (in_valid),
		.acc_i   (accumulator),
		.fsum_i  (filter_sum),
		.bias_i  (bias),
		.mult_i  (multiplier),
		.sh_i    (shift),
		.in_zp   (cfg_q.in_zp),
		.valid_o (v2),
		.x_o     (x2),
		.mult_o  (m2),
		.sh_o    (sh2)
	);

	rq_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.valid_i (v2),
		.x_i     (x2),
		.mult_i  (m2),
		.sh_i    (sh2),
		.valid_o (v4),
		.v_o     (val4),
		.sh_o    (sh4)
	);

	rq_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid_i  (v4),
		.v_i      (val4),
		.sh_i     (sh4),
		.cfg      (cfg_q),
		.valid_o  (out_valid),
		.result_o (result)
	);

endmodule

`default_nettype wire
